[hdl/sphl_pkg.sv]
// shared constants, types and helpers of the salted perfect hash lookup
package sphl_pkg;

	// store depths and derived address widths
	localparam int unsigned SALT_DEPTH  = 4096;
	localparam int unsigned ENTRY_DEPTH = 4096;
	localparam int unsigned SALT_AW     = (SALT_DEPTH > 1) ? $clog2(SALT_DEPTH) : 1;
	localparam int unsigned ENTRY_AW    = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

	// field widths
	localparam int unsigned CNT_W   = 13;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned SALT_W  = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PROD_W  = WORD_W + CNT_W;

	// hash multipliers
	localparam logic [WORD_W-1:0] HASH_MUL_A = 32'd2654435769;
	localparam logic [WORD_W-1:0] HASH_MUL_B = 32'h31415926;

	// item opcodes
	typedef enum logic [1:0] {
		OP_SALT_WR  = 2'd0,
		OP_ENTRY_WR = 2'd1,
		OP_LOOKUP   = 2'd2
	} opcode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_SALT_COUNT  = 2'd0,
		CFG_ENTRY_COUNT = 2'd1,
		CFG_LOOKUP_MODE = 2'd2
	} cfg_index_t;

	// one input beat as it travels down the pipe
	typedef struct packed {
		logic [1:0]        op;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] key;
	} item_t;

	// limit a hash range to the store depth
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] cnt,
		input int unsigned depth);
		return (32'(cnt) > depth) ? CNT_W'(depth) : cnt;
	endfunction

endpackage

[hdl/sphl_scale.sv]
// scaled range reduction: upper bits of hash word times range count
module sphl_scale import sphl_pkg::*; (
	input  logic [WORD_W-1:0] hash_word,
	input  logic [CNT_W-1:0]  range_count,
	output logic [CNT_W-1:0]  slot
);

	logic [PROD_W-1:0] prod;

	// slot = (hash_word * range_count) >> 32, below range_count unless range_count is zero
	assign prod = PROD_W'(hash_word) * PROD_W'(range_count);
	assign slot = prod[PROD_W-1:WORD_W];

endmodule

[hdl/salted_perfect_hash_lookup.sv]
// top level of the salted two-level perfect hash lookup pipeline
//
// Takes one beat per cycle, with any mix of salt writes, entry writes and lookups, unless the
// output stalls; a lookup result leaves the output register after its beat has passed the
// pipe, writes and unused opcodes produce no result. The pipe has nine stages, each
// holding at most one multiplier (key times each hash constant, salt times the first
// constant, the two range scalings) or one memory access; the salt and entry stores are each
// read by every beat and written by write beats at a fixed stage, so writes and lookups see
// the stores in beat order. Bubbles collapse, so new beats are taken while a result waits.
// The stores need no clearing after reset; a lookup must only reach entries already written.
// Configuration writes are always ready and must only be issued while the pipe is empty.
module salted_perfect_hash_lookup import sphl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// input beats
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [IDX_W-1:0]   table_index,
	input  logic [WORD_W-1:0]  write_word,
	input  logic [WORD_W-1:0]  search_key,
	// result beats
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [BYTE_W-1:0]  byte_value,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [CNT_W-1:0]   cfg_data
);

	// configuration registers
	logic [CNT_W-1:0] salt_count_q;
	logic [CNT_W-1:0] entry_count_q;
	logic             mode_q;
	logic [CNT_W-1:0] n_salt;
	logic [CNT_W-1:0] n_entry;

	// stage valid bits and load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_out;

	// stage payloads
	item_t item_s1, item_s2, item_s3, item_s4, item_s5, item_s6, item_s7, item_s8, item_s9;
	logic [WORD_W-1:0]   z_s2, z_s3, z_s4, z_s5, z_s6;
	logic [WORD_W-1:0]   a_s3, a_s4, a_s5, a_s6;
	logic [SALT_AW-1:0]  si_s4;
	logic [SALT_W-1:0]   salt_s5;
	logic [WORD_W-1:0]   sc_s6;
	logic [WORD_W-1:0]   y1_s7;
	logic [ENTRY_AW-1:0] ei_s8;
	logic [WORD_W-1:0]   entry_s9;

	// output register
	logic              out_valid_q;
	logic              found_q;
	logic [BYTE_W-1:0] byte_q;

	// stores
	logic [SALT_W-1:0] salt_mem [SALT_DEPTH];
	logic [WORD_W-1:0] entry_mem [ENTRY_DEPTH];

	// combinational hash pieces
	logic [CNT_W-1:0]  si_raw;
	logic [CNT_W-1:0]  ei_raw;
	logic              salt_wr_ok;
	logic              entry_wr_ok;
	logic              hit;
	logic [BYTE_W-1:0] hit_byte;

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_count_q  <= CNT_W'(1);
			entry_count_q <= CNT_W'(1);
			mode_q        <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SALT_COUNT:  salt_count_q  <= cfg_data;
				CFG_ENTRY_COUNT: entry_count_q <= cfg_data;
				CFG_LOOKUP_MODE: mode_q        <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	assign n_salt  = clamp_count(salt_count_q, SALT_DEPTH);
	assign n_entry = clamp_count(entry_count_q, ENTRY_DEPTH);

	// bubble-collapsing load enables, back from the output
	assign en_out   = !out_valid_q || out_ready;
	assign en_s9    = !vld_s9 || en_out;
	assign en_s8    = !vld_s8 || en_s9;
	assign en_s7    = !vld_s7 || en_s8;
	assign en_s6    = !vld_s6 || en_s7;
	assign en_s5    = !vld_s5 || en_s6;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			vld_s9      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
			if (en_out) out_valid_q <= vld_s9 && (item_s9.op == OP_LOOKUP);
		end
	end

	// first hash range scaling
	sphl_scale u_scale_salt (
		.hash_word   (a_s3 ^ z_s3),
		.range_count (n_salt),
		.slot        (si_raw)
	);

	// second hash range scaling
	sphl_scale u_scale_entry (
		.hash_word   (y1_s7),
		.range_count (n_entry),
		.slot        (ei_raw)
	);

	// write index range checks
	assign salt_wr_ok  = vld_s4 && (item_s4.op == OP_SALT_WR) && (32'(item_s4.idx) < SALT_DEPTH);
	assign entry_wr_ok = vld_s8 && (item_s8.op == OP_ENTRY_WR) &&
		(32'(item_s8.idx) < ENTRY_DEPTH);

	// payload stages
	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1.op   <= opcode;
			item_s1.idx  <= table_index;
			item_s1.word <= write_word;
			item_s1.key  <= search_key;
		end
		// key times second constant
		if (en_s2) begin
			item_s2 <= item_s1;
			z_s2    <= 32'(item_s1.key * HASH_MUL_B);
		end
		// key times first constant
		if (en_s3) begin
			item_s3 <= item_s2;
			z_s3    <= z_s2;
			a_s3    <= 32'(item_s2.key * HASH_MUL_A);
		end
		// salt slot from the unsalted hash
		if (en_s4) begin
			item_s4 <= item_s3;
			z_s4    <= z_s3;
			a_s4    <= a_s3;
			si_s4   <= SALT_AW'(si_raw);
		end
		if (en_s5) begin
			item_s5 <= item_s4;
			z_s5    <= z_s4;
			a_s5    <= a_s4;
		end
		// salt times first constant, added to key product next
		if (en_s6) begin
			item_s6 <= item_s5;
			z_s6    <= z_s5;
			a_s6    <= a_s5;
			sc_s6   <= 32'({{(WORD_W-SALT_W){1'b0}}, salt_s5} * HASH_MUL_A);
		end
		// salted hash word
		if (en_s7) begin
			item_s7 <= item_s6;
			y1_s7   <= 32'(a_s6 + sc_s6) ^ z_s6;
		end
		// entry slot
		if (en_s8) begin
			item_s8 <= item_s7;
			ei_s8   <= ENTRY_AW'(ei_raw);
		end
		if (en_s9) begin
			item_s9 <= item_s8;
		end
		if (en_out) begin
			found_q <= hit;
			byte_q  <= hit_byte;
		end
	end

	// salt store: a read every beat, plus the write of a salt write beat
	always_ff @(posedge clk) begin
		if (en_s5) begin
			if (salt_wr_ok) begin
				salt_mem[SALT_AW'(item_s4.idx)] <= item_s4.word[SALT_W-1:0];
			end
			salt_s5 <= salt_mem[si_s4];
		end
	end

	// entry store: a read every beat, plus the write of an entry write beat
	always_ff @(posedge clk) begin
		if (en_s9) begin
			if (entry_wr_ok) begin
				entry_mem[ENTRY_AW'(item_s8.idx)] <= item_s8.word;
			end
			entry_s9 <= entry_mem[ei_s8];
		end
	end

	// entry compare
	always_comb begin
		hit      = 1'b0;
		hit_byte = '0;
		if (!mode_q) begin
			hit = (entry_s9 == item_s9.key);
		end else if ({{BYTE_W{1'b0}}, entry_s9[WORD_W-1:BYTE_W]} == item_s9.key) begin
			hit      = 1'b1;
			hit_byte = entry_s9[BYTE_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign byte_value = byte_q;

`ifndef SYNTHESIS
	// a byte value only comes with a hit in byte-value mode
	a_byte_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!found || !mode_q) |-> byte_value == '0)
		else $error("byte value without a byte-mode hit");

	// first hash slot stays below the salt range
	a_salt_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && (item_s4.op == OP_LOOKUP) && (n_salt != '0) |-> 32'(si_s4) < 32'(n_salt))
		else $error("salt slot beyond range");

	// an accepted beat lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted beat lost at entry");

	// a held last stage keeps its beat
	a_last_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && !en_s9 |=> vld_s9 && $stable(entry_s9))
		else $error("stalled beat dropped at compare stage");
`endif

endmodule

[sim/tb.sv]
// self-checking testbench of the salted perfect hash lookup pipeline
module tb import sphl_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// hash multipliers, unused codes and run sizes
	localparam logic [31:0] GOLDEN_MUL  = 32'd2654435769;
	localparam logic [31:0] PI_MUL      = 32'h31415926;
	localparam logic [1:0]  OP_NONE     = 2'd3;
	localparam logic [1:0]  CFG_UNUSED  = 2'd3;
	localparam int          POST_DRAIN  = 12;
	localparam int          HOLD_CYCLES = 400;
	localparam int          QUIET_LIMIT = 5000;
	localparam int          NUM_PHASES  = 6;
	localparam int          PHASE_BEATS = 240;
	localparam int          KEY_POOL    = 32;
	localparam int          NUM_ROWS    = 30;

	// register settings of the random phases
	localparam logic [12:0] PH_SALT  [NUM_PHASES] = '{13'd7, 13'd64, 13'd0, 13'd4096,
		13'd8191, 13'd30};
	localparam logic [12:0] PH_ENTRY [NUM_PHASES] = '{13'd19, 13'd200, 13'd8191, 13'd3,
		13'd0, 13'd45};
	localparam logic [12:0] PH_MODE  [NUM_PHASES] = '{13'd0, 13'd1, 13'd0, 13'd1,
		13'd1, 13'd0};

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	// one directed step: an input beat or a register write
	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  code;
		logic [11:0] idx;
		logic [31:0] word;
		logic [31:0] key;
		logic        typed;
		logic        want_found;
		logic [7:0]  want_byte;
	} stim_row_t;

	typedef struct packed {
		logic       found;
		logic [7:0] byte_value;
	} lookup_result_t;

	// directed steps, fixed results only where the slot is plainly index zero
	localparam stim_row_t DIRECTED [NUM_ROWS] = '{
		'{ROW_BEAT, OP_SALT_WR,  12'hFFF, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_SALT_WR,  12'h000, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_ENTRY_WR, 12'hFFF, 32'h0000_0000, 32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_ENTRY_WR, 12'h000, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h0,         1'b1, 1'b0, 8'h00},
		'{ROW_BEAT, OP_NONE,     12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_ENTRY_WR, 12'h000, 32'h0000_0000, 32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h0,         1'b1, 1'b1, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_LOOKUP_MODE, 12'h0, 32'h1,       32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_ENTRY_WR, 12'h000, 32'hFFFF_FFA5, 32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h00FF_FFFF, 1'b1, 1'b1, 8'hA5},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00},
		'{ROW_BEAT, OP_ENTRY_WR, 12'h000, 32'h0000_0012, 32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h0100_0000, 1'b1, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h0,         1'b1, 1'b1, 8'h12},
		'{ROW_CFG,  CFG_UNUSED,  12'h0,   32'h1FFF,      32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_SALT_COUNT,  12'h0, 32'h0,       32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_ENTRY_COUNT, 12'h0, 32'h0,       32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h1234_5678, 1'b1, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h0,         1'b1, 1'b1, 8'h12},
		'{ROW_CFG,  CFG_SALT_COUNT,  12'h0, 32'h1FFF,    32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_ENTRY_COUNT, 12'h0, 32'h1FFF,    32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h00AB_CDEF, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_LOOKUP_MODE, 12'h0, 32'h1FFE,    32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_SALT_COUNT,  12'h0, 32'h1000,    32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  CFG_ENTRY_COUNT, 12'h0, 32'h1000,    32'h0,         1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'h8000_0000, 1'b0, 1'b0, 8'h00},
		'{ROW_BEAT, OP_LOOKUP,   12'h000, 32'h0,         32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00}
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [1:0]        opcode      = '0;
	logic [IDX_W-1:0]  table_index = '0;
	logic [WORD_W-1:0] write_word  = '0;
	logic [WORD_W-1:0] search_key  = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              found;
	logic [BYTE_W-1:0] byte_value;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index   = '0;
	logic [CNT_W-1:0]  cfg_data    = '0;

	// shadow of the block: registers and both stores
	logic [12:0]    cur_salt_count  = 13'd1;
	logic [12:0]    cur_entry_count = 13'd1;
	logic           cur_mode        = 1'b0;
	logic [15:0]    salt_mem  [SALT_DEPTH];
	bit             salt_set  [SALT_DEPTH];
	logic [31:0]    entry_mem [ENTRY_DEPTH];
	bit             entry_set [ENTRY_DEPTH];
	lookup_result_t results_due [$];
	logic [31:0]    known_keys [$];

	int             mismatch_count = 0;
	int             beats_sent     = 0;
	int             quiet_cycles   = 0;
	int unsigned    send_idle_pct  = 0;
	int unsigned    recv_idle_pct  = 0;
	int             hold_left      = 0;
	bit             hold_arm       = 1'b0;
	bit             hold_done      = 1'b0;
	lookup_result_t want_r;
	stim_row_t      row;
	int             phase_start;
	int unsigned    pick;
	logic [31:0]    new_key;

	salted_perfect_hash_lookup u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.table_index(table_index),
		.write_word (write_word),
		.search_key (search_key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.byte_value (byte_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// count-limited hash range, zero stays zero
	function automatic int unsigned range_of(logic [12:0] cnt, int unsigned depth);
		return (32'(cnt) > depth) ? depth : 32'(cnt);
	endfunction

	// multiplicative hash scaled into [0, span), zero for a zero span
	function automatic int unsigned slot_of(logic [31:0] key, logic [15:0] salt,
		int unsigned span);
		logic [31:0] mixed;
		logic [63:0] scaled;
		mixed  = (key + {16'h0, salt}) * GOLDEN_MUL;
		mixed  = mixed ^ (key * PI_MUL);
		scaled = {32'h0, mixed} * 64'(span);
		return scaled[63:32];
	endfunction

	// two-probe lookup against the shadow stores
	function automatic lookup_result_t predict_lookup(logic [31:0] key);
		lookup_result_t r;
		int unsigned    si;
		int unsigned    ei;
		logic [31:0]    ent;
		si  = slot_of(key, 16'h0, range_of(cur_salt_count, SALT_DEPTH));
		ei  = slot_of(key, salt_mem[si], range_of(cur_entry_count, ENTRY_DEPTH));
		ent = entry_mem[ei];
		r   = '0;
		if (!cur_mode) begin
			r.found = (ent == key);
		end else if ({8'h0, ent[31:8]} == key) begin
			r.found      = 1'b1;
			r.byte_value = ent[7:0];
		end
		return r;
	endfunction

	// write position, mostly inside the range in use
	function automatic logic [11:0] pick_slot(logic [12:0] cnt);
		int unsigned span;
		span = range_of(cnt, 4096);
		if (span == 0)
			span = 1;
		if ($urandom_range(9) < 8)
			return 12'($urandom_range(span - 1));
		return 12'($urandom);
	endfunction

	// key source: short keys dominate in byte-value mode
	function automatic logic [31:0] fresh_key();
		if (cur_mode && $urandom_range(9) < 7)
			return $urandom_range(32'h00FF_FFFF);
		if ($urandom_range(9) == 0)
			return $urandom_range(255);
		return $urandom;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// offer one input beat, then update the shadow when it is taken
	task automatic push_beat(input logic [1:0] op, input logic [11:0] idx,
		input logic [31:0] word, input logic [31:0] key,
		input logic typed, input logic want_found, input logic [7:0] want_byte);
		lookup_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		table_index <= idx;
		write_word  <= word;
		search_key  <= key;
		do @(posedge clk); while (!in_ready);
		case (op)
			OP_SALT_WR: begin
				salt_mem[idx] = word[15:0];
				salt_set[idx] = 1'b1;
			end
			OP_ENTRY_WR: begin
				entry_mem[idx] = word;
				entry_set[idx] = 1'b1;
			end
			OP_LOOKUP: begin
				r = predict_lookup(key);
				if (typed)
					r = '{found: want_found, byte_value: want_byte};
				results_due.push_back(r);
			end
			default: ;
		endcase
		beats_sent++;
	endtask

	// lookup preceded by whatever writes keep both probes on written slots
	task automatic issue_lookup(input logic [31:0] key, input bit plant);
		int unsigned si;
		int unsigned ei;
		logic [31:0] content;
		si = slot_of(key, 16'h0, range_of(cur_salt_count, SALT_DEPTH));
		if (!salt_set[si])
			push_beat(OP_SALT_WR, si[11:0], $urandom, $urandom, 1'b0, 1'b0, 8'h00);
		ei = slot_of(key, salt_mem[si], range_of(cur_entry_count, ENTRY_DEPTH));
		if (plant || !entry_set[ei]) begin
			content = cur_mode ? {key[23:0], 8'($urandom)} : key;
			if (!plant && $urandom_range(1) == 0)
				content = $urandom;
			push_beat(OP_ENTRY_WR, ei[11:0], content, $urandom, 1'b0, 1'b0, 8'h00);
		end
		push_beat(OP_LOOKUP, 12'($urandom), $urandom, key, 1'b0, 1'b0, 8'h00);
	endtask

	// register write beat; the caller lowers cfg_valid
	task automatic cfg_write(input logic [1:0] reg_idx, input logic [12:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (reg_idx)
			CFG_SALT_COUNT:  cur_salt_count  = data;
			CFG_ENTRY_COUNT: cur_entry_count = data;
			CFG_LOOKUP_MODE: cur_mode        = data[0];
			default: ;
		endcase
	endtask

	// empty the pipe before touching registers or ending
	task automatic settle_pipe();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (POST_DRAIN) @(posedge clk);
	endtask

	// result check and receiver readiness
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result beat with no lookup outstanding");
			end else begin
				want_r = results_due.pop_front();
				if (found !== want_r.found)
					report_mismatch($sformatf("found got %b want %b", found, want_r.found));
				if (byte_value !== want_r.byte_value)
					report_mismatch($sformatf("byte_value got %02h want %02h",
						byte_value, want_r.byte_value));
			end
		end
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_arm) begin
			hold_arm  = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk
		send_idle_pct = 29;
		recv_idle_pct = 56;
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG) begin
				settle_pipe();
				cfg_write(row.code, row.word[CNT_W-1:0]);
				cfg_valid <= 1'b0;
			end else if (row.code == OP_LOOKUP && !row.typed) begin
				issue_lookup(row.key, 1'b0);
			end else begin
				push_beat(row.code, row.idx, row.word, row.key, row.typed,
					row.want_found, row.want_byte);
			end
		end

		// random phases, one register setting each
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_pipe();
			cfg_write(CFG_SALT_COUNT, PH_SALT[p]);
			cfg_write(CFG_ENTRY_COUNT, PH_ENTRY[p]);
			cfg_write(CFG_LOOKUP_MODE, PH_MODE[p]);
			cfg_valid <= 1'b0;
			send_idle_pct = (p < 2) ? 29 : (p < 4) ? 56 : 0;
			recv_idle_pct = (p < 2) ? 56 : (p < 4) ? 29 : 0;
			phase_start   = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				// long receiver stall while beats keep coming
				if (p == 1 && !hold_done && beats_sent - phase_start >= 60) begin
					hold_arm  = 1'b1;
					hold_done = 1'b1;
				end
				pick = $urandom_range(99);
				if (pick < 40 && known_keys.size() != 0) begin
					issue_lookup(known_keys[$urandom_range(known_keys.size() - 1)], 1'b0);
				end else if (pick < 55) begin
					new_key = fresh_key();
					known_keys.push_back(new_key);
					if (known_keys.size() > KEY_POOL)
						void'(known_keys.pop_front());
					issue_lookup(new_key, 1'b1);
				end else if (pick < 65) begin
					issue_lookup(fresh_key(), 1'b0);
				end else if (pick < 75) begin
					push_beat(OP_SALT_WR, pick_slot(cur_salt_count), $urandom, $urandom,
						1'b0, 1'b0, 8'h00);
				end else if (pick < 92) begin
					push_beat(OP_ENTRY_WR, pick_slot(cur_entry_count), $urandom, $urandom,
						1'b0, 1'b0, 8'h00);
				end else begin
					push_beat(OP_NONE, 12'($urandom), $urandom, $urandom, 1'b0, 1'b0, 8'h00);
				end
			end
		end

		settle_pipe();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
